// ----- sv/acb_pkg.sv -----
// Shared types and constants of the AHCI command builder.
package acb_pkg;

   // Width of a PRDT entry index inside the block; covers up to 64 entries.
   localparam int IDX_WIDTH = 6;

   // Sectors described by one full PRDT entry.
   localparam int SECTORS_PER_ENTRY = 16;

   // Configuration port geometry: one 48-bit register on a 64-bit bus at byte 0.
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 64;
   localparam logic REG_PARTITION_OFFSET = 1'b0;

   // Result item kinds.
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_ENTRY  = 2'd1;
   localparam logic [1:0] KIND_FIS    = 2'd2;
   localparam logic [1:0] KIND_REJECT = 2'd3;

   // ATA opcodes placed in the register FIS.
   localparam logic [7:0] OP_READ_DMA_EXT  = 8'h25;
   localparam logic [7:0] OP_WRITE_DMA_EXT = 8'h35;

   // Fixed descriptor values.
   localparam logic [4:0]  FIS_DWORDS      = 5'd5;
   localparam logic [12:0] FULL_ENTRY_BCM1 = 13'h1FFF;
   localparam logic [8:0]  SECTOR_BCM1     = 9'h1FF;
   localparam logic [31:0] ENTRY_BYTES     = 32'd8192;

   // Request as presented on the input channel.
   typedef struct packed {
      logic        cmd;
      logic [47:0] start_lba;
      logic [15:0] sector_count;
      logic [31:0] buffer_address;
      logic [31:0] busy_slot_mask;
   } req_payload_type;

   // Descriptor item as presented on the result channel.
   typedef struct packed {
      logic [1:0]  item_kind;
      logic [4:0]  slot;
      logic        is_write;
      logic [4:0]  fis_length_dwords;
      logic [3:0]  entry_count;
      logic [2:0]  entry_index;
      logic [31:0] data_address;
      logic [12:0] byte_count_minus_one;
      logic [7:0]  ata_command;
      logic [47:0] lba;
      logic [15:0] fis_sector_count;
      logic        last;
   } rsp_payload_type;

   // Classified request handed from the front end to the sequencer.
   typedef struct packed {
      logic                 rejected;
      logic [4:0]           slot;
      logic                 is_write;
      logic [IDX_WIDTH-1:0] last_idx;
      logic [3:0]           rem_m1;
      logic [31:0]          buffer_address;
      logic [47:0]          lba;
      logic [15:0]          sector_count;
   } queue_entry_type;

endpackage

// ----- sv/acb_front.sv -----
// Front end: accepts requests, picks the slot, checks the count and forms the absolute LBA.
module acb_front #(
   parameter int MAX_ENTRIES = 8
) (
   input  logic                     req_valid,
   output logic                     req_ready,
   input  acb_pkg::req_payload_type req_payload,
   input  logic [47:0]              partition_offset,
   input  logic                     queue_full,
   output logic                     push,
   output acb_pkg::queue_entry_type push_entry
);

   localparam int CAPACITY = MAX_ENTRIES * acb_pkg::SECTORS_PER_ENTRY;

   logic [31:0] free_mask;
   logic [31:0] lowest_free;
   logic [4:0]  slot;
   logic        slot_found;
   logic [15:0] count_m1;
   logic        count_bad;

   // A transfer is taken whenever the queue has room.
   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;

   // Isolate the lowest clear bit of the busy mask.
   assign free_mask   = ~req_payload.busy_slot_mask;
   assign lowest_free = free_mask & (~free_mask + 32'd1);
   assign slot_found  = |free_mask;

   // Encode the one-hot slot into its number.
   always_comb begin
      slot = '0;
      for (int i = 0; i < 32; i++) begin
         if (lowest_free[i]) begin
            slot = slot | 5'(i);
         end
      end
   end

   // Zero sectors, or more than the table can describe, is refused.
   assign count_m1  = req_payload.sector_count - 16'd1;
   assign count_bad = (req_payload.sector_count == 16'd0) ||
                      (req_payload.sector_count > 16'(CAPACITY));

   // Build the classified entry for the queue.
   always_comb begin
      push_entry.rejected       = !slot_found || count_bad;
      push_entry.slot           = slot;
      push_entry.is_write       = req_payload.cmd;
      push_entry.last_idx       = count_m1[acb_pkg::IDX_WIDTH+3:4];
      push_entry.rem_m1         = count_m1[3:0];
      push_entry.buffer_address = req_payload.buffer_address;
      push_entry.lba            = req_payload.start_lba + partition_offset;
      push_entry.sector_count   = req_payload.sector_count;
   end

endmodule

// ----- sv/acb_queue.sv -----
// Two-entry queue that decouples the front end from the descriptor sequencer.
module acb_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  acb_pkg::queue_entry_type push_entry,
   input  logic                     pop,
   output logic                     full,
   output logic                     head_valid,
   output acb_pkg::queue_entry_type head_entry
);

   acb_pkg::queue_entry_type mem_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_entry = mem_ff[rd_ptr_ff];

   // Pointer and fill updates.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- sv/acb_back.sv -----
// Descriptor sequencer: emits header, PRDT entries and register FIS through an output register.
module acb_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  acb_pkg::queue_entry_type head_entry,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output acb_pkg::rsp_payload_type rsp_payload
);

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_ENTRY,
      PH_FIS
   } phase_type;

   phase_type                       phase_ff;
   phase_type                       phase_in;
   logic [acb_pkg::IDX_WIDTH-1:0]   idx_ff;
   logic [acb_pkg::IDX_WIDTH-1:0]   idx_in;
   logic [31:0]                     addr_ff;
   logic [31:0]                     addr_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   acb_pkg::rsp_payload_type        rsp_payload_ff;
   acb_pkg::rsp_payload_type        rsp_payload_in;
   logic                            advance;
   logic                            last_entry;
   logic [3:0]                      entry_count;

   // The output register may be reloaded when empty or being drained.
   assign advance     = !rsp_valid_ff || rsp_ready;
   assign last_entry  = (idx_ff == head_entry.last_idx);
   assign entry_count = 4'(head_entry.last_idx + 1'b1);

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Next item, phase and entry position.
   always_comb begin
      phase_in       = phase_ff;
      idx_in         = idx_ff;
      addr_in        = addr_ff;
      pop            = 1'b0;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (advance) begin
         rsp_valid_in   = head_valid;
         rsp_payload_in = '0;
         if (head_valid) begin
            if (head_entry.rejected) begin
               rsp_payload_in.item_kind = acb_pkg::KIND_REJECT;
               rsp_payload_in.last      = 1'b1;
               pop                      = 1'b1;
            end else begin
               rsp_payload_in.slot        = head_entry.slot;
               rsp_payload_in.is_write    = head_entry.is_write;
               rsp_payload_in.entry_count = entry_count;
               unique case (phase_ff)
                  PH_HEADER: begin
                     rsp_payload_in.item_kind         = acb_pkg::KIND_HEADER;
                     rsp_payload_in.fis_length_dwords = acb_pkg::FIS_DWORDS;
                     phase_in = PH_ENTRY;
                     idx_in   = '0;
                     addr_in  = head_entry.buffer_address;
                  end
                  PH_ENTRY: begin
                     rsp_payload_in.item_kind    = acb_pkg::KIND_ENTRY;
                     rsp_payload_in.entry_index  = idx_ff[2:0];
                     rsp_payload_in.data_address = addr_ff;
                     // The final entry carries the remainder of the sectors.
                     rsp_payload_in.byte_count_minus_one = last_entry
                        ? {head_entry.rem_m1, acb_pkg::SECTOR_BCM1}
                        : acb_pkg::FULL_ENTRY_BCM1;
                     idx_in   = idx_ff + 1'b1;
                     addr_in  = addr_ff + acb_pkg::ENTRY_BYTES;
                     phase_in = last_entry ? PH_FIS : PH_ENTRY;
                  end
                  PH_FIS: begin
                     rsp_payload_in.item_kind        = acb_pkg::KIND_FIS;
                     rsp_payload_in.ata_command      = head_entry.is_write
                        ? acb_pkg::OP_WRITE_DMA_EXT : acb_pkg::OP_READ_DMA_EXT;
                     rsp_payload_in.lba              = head_entry.lba;
                     rsp_payload_in.fis_sector_count = head_entry.sector_count;
                     rsp_payload_in.last             = 1'b1;
                     phase_in = PH_HEADER;
                     pop      = 1'b1;
                  end
                  default: begin
                     phase_in = PH_HEADER;
                  end
               endcase
            end
         end
      end
   end

   // State and registered outputs; payload and position registers need no reset.
   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      addr_ff        <= addr_in;
      rsp_payload_ff <= rsp_payload_in;
      if (reset) begin
         phase_ff     <= PH_HEADER;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- sv/ahci_command_builder.sv -----
// A transferred request is written into the queue; its first item is then loaded into the
// output register. The sequencer emits one item per cycle unless the result channel stalls;
// a request gives entries + 2 items (3 to MAX_ENTRIES + 2), a rejected request a single item.
// A two-entry queue lets new requests be taken while earlier ones are still emitted.
// Reset (synchronous, active high) empties the queue and output register and clears
// the partition offset to zero.
module ahci_command_builder #(
   parameter int MAX_ENTRIES = 8  // 1 to 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  acb_pkg::req_payload_type              req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output acb_pkg::rsp_payload_type              rsp_payload,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [acb_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [acb_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [acb_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                  csr_pready
);

   logic [47:0]              partition_offset_ff;
   logic [47:0]              partition_offset_in;
   logic                     csr_write;
   logic                     sel_offset;
   logic                     push;
   logic                     pop;
   logic                     queue_full;
   logic                     head_valid;
   acb_pkg::queue_entry_type push_entry;
   acb_pkg::queue_entry_type head_entry;

   // Register decode: the offset register occupies the first eight bytes.
   assign csr_pready = 1'b1;
   assign sel_offset = (csr_paddr[3] == acb_pkg::REG_PARTITION_OFFSET);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = sel_offset ? {16'd0, partition_offset_ff} : '0;

   assign partition_offset_in = (csr_write && sel_offset) ? csr_pwdata[47:0]
                                                           : partition_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         partition_offset_ff <= '0;
      end else begin
         partition_offset_ff <= partition_offset_in;
      end
   end

   acb_front #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .partition_offset (partition_offset_ff),
      .queue_full       (queue_full),
      .push             (push),
      .push_entry       (push_entry)
   );

   acb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   acb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_entry  (head_entry),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- sv/acb_checker.sv -----
// Port-level checks of the AHCI command builder, bound to the top level.
module acb_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input acb_pkg::rsp_payload_type rsp_payload
);

   logic [2:0] outstanding_ff;
   logic [2:0] outstanding_in;
   logic       run_start_ff;
   logic       run_start_in;
   logic       req_xfer;
   logic       rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   // Count requests whose runs have not yet ended, and track run boundaries.
   always_comb begin
      outstanding_in = outstanding_ff + {2'd0, req_xfer}
                       - {2'd0, rsp_xfer && rsp_payload.last};
      run_start_in   = rsp_xfer ? rsp_payload.last : run_start_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
         run_start_ff   <= 1'b1;
      end else begin
         outstanding_ff <= outstanding_in;
         run_start_ff   <= run_start_in;
      end
   end

   // A stalled result holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // Reset empties the output.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Every result belongs to an accepted request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != 3'd0)
      else $error("result without an outstanding request");

   // A run opens with a command header or a rejection.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && run_start_ff |->
         rsp_payload.item_kind == acb_pkg::KIND_HEADER ||
         rsp_payload.item_kind == acb_pkg::KIND_REJECT)
      else $error("run does not start with a header or rejection");

endmodule

bind ahci_command_builder acb_checker u_checker (.*);

// ----- sim/tb_ahci_command_builder.sv -----
// Self-checking testbench of the AHCI command builder: random and directed requests, scoreboard.
module tb_ahci_command_builder;

   // Geometry the predictor assumes; the block is built with the same table size.
   localparam int PRD_LIMIT        = 8;
   localparam int SECTORS_PER_PRD  = 16;
   localparam int SECTOR_SIZE      = 512;
   localparam int PRD_SPAN_BYTES   = 8192;
   localparam int MAX_SECTORS      = PRD_LIMIT * SECTORS_PER_PRD;
   localparam int RANDOM_PER_PHASE = 51;
   localparam int RESPONDER_HOLD   = 80;
   localparam int SETTLE_CYCLES    = 6;
   localparam int WATCHDOG_LIMIT   = 1000;
   localparam int REPORT_LIMIT     = 10;
   localparam int ADDR_W           = acb_pkg::CSR_ADDR_WIDTH;
   localparam int DATA_W           = acb_pkg::CSR_DATA_WIDTH;

   // Predicts the descriptor items of each request and checks them in order.
   class descriptor_tracker;
      logic [47:0]              partition_offset;
      acb_pkg::rsp_payload_type pending_descriptors[$];
      int                       mismatch_count;

      function new();
         partition_offset = '0;
         mismatch_count   = 0;
      endfunction

      function int outstanding();
         return pending_descriptors.size();
      endfunction

      // Work out the items one accepted request must produce.
      function void note_request(acb_pkg::req_payload_type r);
         acb_pkg::rsp_payload_type item;
         int                       slot_no;
         bit                       found;
         int                       prd_total;
         int                       secs;
         logic [47:0]              abs_lba;
         found   = 1'b0;
         slot_no = 0;
         for (int i = 0; i < 32; i++) begin
            if (!found && !r.busy_slot_mask[i]) begin
               slot_no = i;
               found   = 1'b1;
            end
         end
         // A full slot mask or an unusable count gives a single rejection.
         if (!found || r.sector_count == 0 || int'(r.sector_count) > MAX_SECTORS) begin
            item           = '0;
            item.item_kind = acb_pkg::KIND_REJECT;
            item.last      = 1'b1;
            pending_descriptors.push_back(item);
            return;
         end
         prd_total = (int'(r.sector_count) - 1) / SECTORS_PER_PRD + 1;
         abs_lba   = r.start_lba + partition_offset;
         // Command header.
         item                   = '0;
         item.item_kind         = acb_pkg::KIND_HEADER;
         item.slot              = 5'(slot_no);
         item.is_write          = r.cmd;
         item.fis_length_dwords = acb_pkg::FIS_DWORDS;
         item.entry_count       = 4'(prd_total);
         pending_descriptors.push_back(item);
         // One PRDT entry per 16 sectors; the last one takes the remainder.
         for (int i = 0; i < prd_total; i++) begin
            secs = (i + 1 < prd_total) ? SECTORS_PER_PRD
                                       : int'(r.sector_count) - i * SECTORS_PER_PRD;
            item                      = '0;
            item.item_kind            = acb_pkg::KIND_ENTRY;
            item.slot                 = 5'(slot_no);
            item.is_write             = r.cmd;
            item.entry_count          = 4'(prd_total);
            item.entry_index          = 3'(i);
            item.data_address         = r.buffer_address + 32'(i) * 32'(PRD_SPAN_BYTES);
            item.byte_count_minus_one = 13'(secs * SECTOR_SIZE - 1);
            pending_descriptors.push_back(item);
         end
         // Register FIS carrying the full count and the absolute sector.
         item                  = '0;
         item.item_kind        = acb_pkg::KIND_FIS;
         item.slot             = 5'(slot_no);
         item.is_write         = r.cmd;
         item.entry_count      = 4'(prd_total);
         item.ata_command      = r.cmd ? acb_pkg::OP_WRITE_DMA_EXT : acb_pkg::OP_READ_DMA_EXT;
         item.lba              = abs_lba;
         item.fis_sector_count = r.sector_count;
         item.last             = 1'b1;
         pending_descriptors.push_back(item);
      endfunction

      function void compare_field(string field_name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("mismatch in %s: expected %0h, got %0h", field_name, want, got);
         end
      endfunction

      // Compare one transferred result item with the oldest expectation.
      function void check_item(acb_pkg::rsp_payload_type got);
         acb_pkg::rsp_payload_type want;
         if (pending_descriptors.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected result item of kind %0d", got.item_kind);
            return;
         end
         want = pending_descriptors.pop_front();
         compare_field("item_kind", 64'(want.item_kind), 64'(got.item_kind));
         compare_field("slot", 64'(want.slot), 64'(got.slot));
         compare_field("is_write", 64'(want.is_write), 64'(got.is_write));
         compare_field("fis_length_dwords", 64'(want.fis_length_dwords),
                       64'(got.fis_length_dwords));
         compare_field("entry_count", 64'(want.entry_count), 64'(got.entry_count));
         compare_field("entry_index", 64'(want.entry_index), 64'(got.entry_index));
         compare_field("data_address", 64'(want.data_address), 64'(got.data_address));
         compare_field("byte_count_minus_one", 64'(want.byte_count_minus_one),
                       64'(got.byte_count_minus_one));
         compare_field("ata_command", 64'(want.ata_command), 64'(got.ata_command));
         compare_field("lba", 64'(want.lba), 64'(got.lba));
         compare_field("fis_sector_count", 64'(want.fis_sector_count),
                       64'(got.fis_sector_count));
         compare_field("last", 64'(want.last), 64'(got.last));
      endfunction
   endclass

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       req_valid   = 1'b0;
   logic                       req_ready;
   acb_pkg::req_payload_type   req_payload = '0;
   logic                       rsp_valid;
   logic                       rsp_ready   = 1'b0;
   acb_pkg::rsp_payload_type   rsp_payload;
   logic                       csr_psel    = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite  = 1'b0;
   logic [ADDR_W-1:0]          csr_paddr   = '0;
   logic [DATA_W-1:0]          csr_pwdata  = '0;
   logic [DATA_W-1:0]          csr_prdata;
   logic                       csr_pready;

   descriptor_tracker tracker;
   bit                calm         = 1'b0;
   bit                hold_request = 1'b0;
   wire               any_transfer = (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
                                     (csr_psel && csr_penable && csr_pwrite && csr_pready);

   ahci_command_builder #(.MAX_ENTRIES(PRD_LIMIT)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Result side: random back-pressure, calm stretches and one long hold-off.
   initial begin : responder
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = RESPONDER_HOLD - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 28);
         end
      end
   end

   // Every result transfer is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_item(rsp_payload);
   end

   // Ends the run if no transfer of any kind happens for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || any_transfer)
            quiet = 0;
         else
            quiet++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // Offer one request, with random idle cycles first, and hold it until transferred.
   task automatic send_request(acb_pkg::req_payload_type r);
      while (!calm && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do
         @(posedge clock);
      while (!req_ready);
      tracker.note_request(r);
   endtask

   // Stop offering and wait until every expected item has been transferred.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write of the partition offset: a setup phase, then an access phase until ready.
   task automatic write_partition_offset(logic [47:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_W'(8 * int'(acb_pkg::REG_PARTITION_OFFSET));
      csr_pwdata  <= DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      tracker.partition_offset = value;
   endtask

   function automatic acb_pkg::req_payload_type make_req(logic wr, logic [47:0] lba,
                                                         int count, logic [31:0] buf_addr,
                                                         logic [31:0] busy);
      acb_pkg::req_payload_type r;
      r.cmd            = wr;
      r.start_lba      = lba;
      r.sector_count   = 16'(count);
      r.buffer_address = buf_addr;
      r.busy_slot_mask = busy;
      return r;
   endfunction

   function automatic logic [47:0] random_lba48();
      logic [63:0] wide;
      wide = {$urandom, $urandom};
      return wide[47:0];
   endfunction

   // Random request, weighted towards valid counts and masks with a free slot.
   function automatic acb_pkg::req_payload_type random_request();
      acb_pkg::req_payload_type r;
      int                       pick;
      int                       k;
      r.cmd = 1'($urandom_range(1));
      pick  = $urandom_range(99);
      if (pick < 10)
         r.start_lba = '0;
      else if (pick < 20)
         r.start_lba = '1;
      else
         r.start_lba = random_lba48();
      // Counts: mostly legal, many on entry boundaries, a few rejected.
      pick = $urandom_range(99);
      if (pick < 5)
         r.sector_count = '0;
      else if (pick < 11)
         r.sector_count = 16'($urandom_range(65535, MAX_SECTORS + 1));
      else if (pick < 35)
         r.sector_count = 16'(SECTORS_PER_PRD * $urandom_range(PRD_LIMIT, 1)
                              + $urandom_range(2) - 1);
      else
         r.sector_count = 16'($urandom_range(MAX_SECTORS, 1));
      pick = $urandom_range(99);
      if (pick < 10)
         r.buffer_address = 32'hFFFF_0000 | 32'($urandom_range(16'hFFFF));
      else
         r.buffer_address = $urandom;
      // Busy masks that put the free slot at every position, plus a full mask now and then.
      pick = $urandom_range(99);
      k    = $urandom_range(31);
      if (pick < 5)
         r.busy_slot_mask = '1;
      else if (pick < 15)
         r.busy_slot_mask = '0;
      else if (pick < 35)
         r.busy_slot_mask = ~(32'h1 << k);
      else if (pick < 55)
         r.busy_slot_mask = (32'h1 << k) - 32'h1;
      else if (pick < 75)
         r.busy_slot_mask = $urandom | $urandom;
      else
         r.busy_slot_mask = $urandom;
      return r;
   endfunction

   initial begin : stimulus
      logic [47:0] phase_offset;
      tracker = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at zero offset: boundaries, slot positions and each rejection reason.
      send_request(make_req(1'b0, 48'h0, 1, 32'h0, 32'h0));
      send_request(make_req(1'b1, '1, 16, 32'hFFFF_FFFF, 32'h0000_0001));
      send_request(make_req(1'b0, 48'h1234_5678_9ABC, 17, 32'h0000_1000, 32'h7FFF_FFFF));
      send_request(make_req(1'b1, 48'h8000_0000_0000, 128, 32'hFFFF_C000, 32'h0000_FFFF));
      send_request(make_req(1'b0, 48'h10, 127, 32'h2000, 32'hFFFF_FFFF));
      send_request(make_req(1'b1, 48'h20, 0, 32'h3000, 32'h0));
      send_request(make_req(1'b0, 48'h30, 129, 32'h4000, 32'h0));
      send_request(make_req(1'b1, 48'h40, 65535, 32'h5000, 32'h0));
      send_request(make_req(1'b0, 48'h7FFF_FFFF_FFFF, 113, 32'hDEAD_BEE0, 32'hAAAA_AAAB));
      send_request(make_req(1'b1, 48'h1, 15, 32'h0, 32'h0));
      send_request(make_req(1'b0, '1, 112, 32'h8000_0000, 32'h0));
      send_request(make_req(1'b1, 48'hFFFF, 33, 32'h1234_5678, 32'h5555_5555));

      // Largest offset, so that the absolute sector wraps at 48 bits.
      wait_for_results();
      write_partition_offset('1);
      send_request(make_req(1'b0, 48'h1, 8, 32'h100, 32'h0));
      send_request(make_req(1'b1, '1, 1, 32'h200, 32'hFFFF_FFF0));
      send_request(make_req(1'b0, 48'h0, 48, 32'h300, 32'h3));

      // Random phases, each under its own offset.
      for (int phase = 0; phase < 4; phase++) begin
         wait_for_results();
         case (phase)
            0: phase_offset = random_lba48();
            1: phase_offset = '0;
            2: phase_offset = 48'($urandom_range(1000));
            default: phase_offset = 48'h8000_0000_0000;
         endcase
         write_partition_offset(phase_offset);
         calm = (phase == 1);
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            // Long receiver hold-off while requests keep coming, so the queue fills.
            if (phase == 1 && n == 10)
               hold_request = 1'b1;
            // Sender pause until every outstanding item has been transferred.
            if (phase == 3 && n == 25)
               wait_for_results();
            send_request(random_request());
         end
      end
      calm = 1'b0;

      wait_for_results();
      repeat (20) @(posedge clock);
      if (tracker.mismatch_count == 0 && tracker.outstanding() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
